// ----- design/erb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// erb_pkg: shared types and constants
// Request and opcode codes, and the control word that the execute stage hands
// to the writeback stage of the 8-bit RISC executor.
// ---------------------------------------------------------------------------
package erb_pkg;

  localparam int REG_COUNT = 16;
  localparam int REG_AW    = 4;
  localparam int BYTE_SPAN = 256;

  typedef enum logic [1:0] {
    REQ_LOAD_DATA = 2'd0,
    REQ_LOAD_REG  = 2'd1,
    REQ_READ_DATA = 2'd2,
    REQ_EXEC      = 2'd3
  } req_t;

  // Opcodes 12 to 14 are no-ops and fall to the default arm
  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_INC   = 4'd3,
    OP_AND   = 4'd4,
    OP_OR    = 4'd5,
    OP_NOT   = 4'd6,
    OP_XOR   = 4'd7,
    OP_LOAD  = 4'd8,
    OP_STORE = 4'd9,
    OP_JMP   = 4'd10,
    OP_BEQZ  = 4'd11,
    OP_HALT  = 4'd15
  } op_t;

  // Execute-stage result carried into the writeback/output stage
  typedef struct packed {
    logic              rf_we;         // register file write (load reg or ALU/load op)
    logic [REG_AW-1:0] rf_idx;
    logic [7:0]        rf_val;
    logic              use_mem_data;  // write value comes from data RAM read
    logic              reg_written;
    logic              read_req;
    logic              mem_written;
    logic [7:0]        mem_address;
    logic [7:0]        mem_value;
    logic              branch_taken;
    logic [7:0]        next_pc;
    logic              halted;
  } exec_res_t;

endpackage : erb_pkg
`default_nettype wire

// ----- design/eight_bit_risc_instruction_executor.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one word per cycle while out_stall is low; the three register-file
//   RAM copies give the three operand reads and the data RAM takes one read or
//   write per word. An accepted word waits in the stage 1 registers until stage 2
//   is free, then its result is held in the output register and shown from there.
// Reset: pc and halt flag clear to zero; register file and data memory are not
//   cleared and hold undefined data until written.
// ---------------------------------------------------------------------------
// eight_bit_risc_instruction_executor: top level
// Two-stage core: stage 1 reads the register file, executes and accesses the
// data RAM; stage 2 is the output register and writes the register file back.
// ---------------------------------------------------------------------------
module eight_bit_risc_instruction_executor
  import erb_pkg::*;
#(
  parameter int DATA_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [7:0]  in_address,
  input  wire logic [7:0]  in_load_value,
  input  wire logic [15:0] in_instruction,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [7:0]  out_next_pc,
  output      logic        out_halted,
  output      logic [7:0]  out_read_data,
  output      logic        out_reg_written,
  output      logic [3:0]  out_reg_index,
  output      logic [7:0]  out_reg_value,
  output      logic        out_mem_written,
  output      logic [7:0]  out_mem_address,
  output      logic [7:0]  out_mem_value,
  output      logic        out_branch_taken
);

  localparam int AW = $clog2(DATA_DEPTH);

  logic        s1_valid_r, s1_valid_nxt;
  req_t        s1_req_r;
  logic [7:0]  s1_address_r;
  logic [7:0]  s1_load_value_r;
  logic [15:0] s1_instruction_r;
  logic        s2_valid_r, s2_valid_nxt;
  exec_res_t   s2_res_r;
  logic [7:0]  pc_r, pc_nxt;
  logic        halt_r, halt_nxt;

  logic        in_accept, out_accept, s2_free, s1_adv;
  logic [7:0]  rf_a, rf_b, rf_d;
  logic        rf_we;
  logic [7:0]  fwd_val;
  logic        fwd_we;
  exec_res_t   exec_res;
  logic        dmem_we, dmem_re;
  logic [AW-1:0] dmem_idx;
  logic [7:0]  dmem_wdata, dmem_rdata;

  // Handshake and stage advance
  always_comb begin
    out_valid    = s2_valid_r;
    out_accept   = s2_valid_r && !out_stall;
    s2_free      = !s2_valid_r || !out_stall;
    s1_adv       = s1_valid_r && s2_free;
    in_stall     = s1_valid_r && !s2_free;
    in_accept    = in_valid && !in_stall;
    s1_valid_nxt = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    s2_valid_nxt = s1_adv ? 1'b1 : (out_accept ? 1'b0 : s2_valid_r);
  end

  // Pending register write in the output stage
  always_comb begin
    fwd_val = s2_res_r.use_mem_data ? dmem_rdata : s2_res_r.rf_val;
    fwd_we  = s2_valid_r && s2_res_r.rf_we;
    rf_we   = out_accept && s2_res_r.rf_we;
  end

  // Register file: one copy per operand port
  erb_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (s2_res_r.rf_idx),
    .wdata (fwd_val),
    .re    (in_accept),
    .raddr (in_instruction[7:4]),
    .rdata (rf_a)
  );

  erb_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (s2_res_r.rf_idx),
    .wdata (fwd_val),
    .re    (in_accept),
    .raddr (in_instruction[3:0]),
    .rdata (rf_b)
  );

  erb_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_rf_d (
    .clk   (clk),
    .we    (rf_we),
    .waddr (s2_res_r.rf_idx),
    .wdata (fwd_val),
    .re    (in_accept),
    .raddr (in_instruction[11:8]),
    .rdata (rf_d)
  );

  erb_exec #(.DATA_DEPTH(DATA_DEPTH)) u_exec (
    .req         (s1_req_r),
    .address     (s1_address_r),
    .load_value  (s1_load_value_r),
    .instruction (s1_instruction_r),
    .pc          (pc_r),
    .halt        (halt_r),
    .rf_a        (rf_a),
    .rf_b        (rf_b),
    .rf_d        (rf_d),
    .fwd_we      (fwd_we),
    .fwd_idx     (s2_res_r.rf_idx),
    .fwd_val     (fwd_val),
    .res         (exec_res),
    .pc_nxt      (pc_nxt),
    .halt_nxt    (halt_nxt),
    .dmem_we     (dmem_we),
    .dmem_re     (dmem_re),
    .dmem_idx    (dmem_idx),
    .dmem_wdata  (dmem_wdata)
  );

  // Data memory: accessed in order as each word leaves stage 1
  erb_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_dmem (
    .clk   (clk),
    .we    (s1_adv && dmem_we),
    .waddr (dmem_idx),
    .wdata (dmem_wdata),
    .re    (s1_adv && dmem_re),
    .raddr (dmem_idx),
    .rdata (dmem_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      pc_r       <= 8'd0;
      halt_r     <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      if (s1_adv) begin
        pc_r   <= pc_nxt;
        halt_r <= halt_nxt;
      end
    end
  end

  // Capture the input word and advance the stage 1 result
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r         <= req_t'(in_req_type);
      s1_address_r     <= in_address;
      s1_load_value_r  <= in_load_value;
      s1_instruction_r <= in_instruction;
    end
    if (s1_adv) begin
      s2_res_r <= exec_res;
    end
  end

  // Drive the result word
  always_comb begin
    out_next_pc      = s2_res_r.next_pc;
    out_halted       = s2_res_r.halted;
    out_read_data    = s2_res_r.read_req ? dmem_rdata : 8'd0;
    out_reg_written  = s2_res_r.reg_written;
    out_reg_index    = s2_res_r.reg_written ? s2_res_r.rf_idx : 4'd0;
    out_reg_value    = s2_res_r.reg_written ? fwd_val : 8'd0;
    out_mem_written  = s2_res_r.mem_written;
    out_mem_address  = s2_res_r.mem_address;
    out_mem_value    = s2_res_r.mem_value;
    out_branch_taken = s2_res_r.branch_taken;
  end

endmodule : eight_bit_risc_instruction_executor
`default_nettype wire

// ----- design/erb_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// erb_ram: generic single-write, single-read synchronous RAM
// Registered read with enable; a read of the address written in the same
// cycle returns the new data.
// ---------------------------------------------------------------------------
module erb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then read with write-first bypass; hold read data when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule : erb_ram
`default_nettype wire

// ----- design/erb_exec.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// erb_exec: execute stage
// Forwards the pending register write, runs the ALU, forms the data address
// and the next pc, and drives the data RAM access for the word in stage 1.
// ---------------------------------------------------------------------------
module erb_exec
  import erb_pkg::*;
#(
  parameter int DATA_DEPTH = 256
) (
  input  wire req_t                          req,
  input  wire logic [7:0]                    address,
  input  wire logic [7:0]                    load_value,
  input  wire logic [15:0]                   instruction,
  input  wire logic [7:0]                    pc,
  input  wire logic                          halt,
  input  wire logic [7:0]                    rf_a,
  input  wire logic [7:0]                    rf_b,
  input  wire logic [7:0]                    rf_d,
  input  wire logic                          fwd_we,
  input  wire logic [REG_AW-1:0]             fwd_idx,
  input  wire logic [7:0]                    fwd_val,
  output      exec_res_t                     res,
  output      logic [7:0]                    pc_nxt,
  output      logic                          halt_nxt,
  output      logic                          dmem_we,
  output      logic                          dmem_re,
  output      logic [$clog2(DATA_DEPTH)-1:0] dmem_idx,
  output      logic [7:0]                    dmem_wdata
);

  localparam int AW = $clog2(DATA_DEPTH);

  // Byte address to data RAM index, folded at elaboration
  logic [AW-1:0] mod_tbl [BYTE_SPAN];
  for (genvar i = 0; i < BYTE_SPAN; i++) begin : g_mod
    localparam logic [AW-1:0] IDX = AW'(i % DATA_DEPTH);
    assign mod_tbl[i] = IDX;
  end

  op_t               op;
  logic [REG_AW-1:0] r1, r2, r3;
  logic [7:0]        a, b, d;
  logic [7:0]        pc2;
  logic [7:0]        sum;
  logic [7:0]        raw_addr;
  logic [15:0]       prod;
  logic [7:0]        val;
  logic              wr;

  // Decode and forward the write still waiting in the output stage
  always_comb begin
    op  = op_t'(instruction[15:12]);
    r1  = instruction[11:8];
    r2  = instruction[7:4];
    r3  = instruction[3:0];
    a   = (fwd_we && (fwd_idx == r2)) ? fwd_val : rf_a;
    b   = (fwd_we && (fwd_idx == r3)) ? fwd_val : rf_b;
    d   = (fwd_we && (fwd_idx == r1)) ? fwd_val : rf_d;
    pc2 = pc + 8'd2;
    sum = a + {4'b0000, r3};
    raw_addr = (req == REQ_EXEC) ? sum : address;
    dmem_idx = mod_tbl[raw_addr];
    prod = a * b;
  end

  // Execute one word
  always_comb begin
    res        = '0;
    pc_nxt     = pc;
    halt_nxt   = halt;
    dmem_we    = 1'b0;
    dmem_re    = 1'b0;
    dmem_wdata = load_value;
    val        = 8'd0;
    wr         = 1'b0;
    unique case (req)
      REQ_LOAD_DATA: begin
        dmem_we = 1'b1;
      end
      REQ_LOAD_REG: begin
        res.rf_we  = 1'b1;
        res.rf_idx = address[REG_AW-1:0];
        res.rf_val = load_value;
      end
      REQ_READ_DATA: begin
        dmem_re      = 1'b1;
        res.read_req = 1'b1;
      end
      REQ_EXEC: begin
        if (!halt) begin
          pc_nxt = pc2;
          unique case (op)
            OP_ADD: begin wr = 1'b1; val = a + b;   end
            OP_SUB: begin wr = 1'b1; val = a - b;   end
            OP_MUL: begin wr = 1'b1; val = prod[7:0]; end
            OP_INC: begin wr = 1'b1; val = d + 8'd1; end
            OP_AND: begin wr = 1'b1; val = a & b;   end
            OP_OR:  begin wr = 1'b1; val = a | b;   end
            OP_NOT: begin wr = 1'b1; val = ~a;      end
            OP_XOR: begin wr = 1'b1; val = a ^ b;   end
            OP_LOAD: begin
              wr               = 1'b1;
              dmem_re          = 1'b1;
              res.use_mem_data = 1'b1;
            end
            OP_STORE: begin
              dmem_we         = 1'b1;
              dmem_wdata      = d;
              res.mem_written = 1'b1;
              res.mem_address = 8'(dmem_idx);
              res.mem_value   = d;
            end
            OP_JMP: begin
              pc_nxt           = pc2 + {instruction[10:4], 1'b0};
              res.branch_taken = 1'b1;
            end
            OP_BEQZ: begin
              if (d == 8'd0) begin
                pc_nxt           = pc2 + {instruction[6:0], 1'b0};
                res.branch_taken = 1'b1;
              end
            end
            OP_HALT: begin
              halt_nxt = 1'b1;
            end
            default: begin
            end
          endcase
          if (wr) begin
            res.rf_we       = 1'b1;
            res.reg_written = 1'b1;
            res.rf_idx      = r1;
            res.rf_val      = val;
          end
        end
      end
    endcase
    res.next_pc = pc_nxt;
    res.halted  = halt_nxt;
  end

endmodule : erb_exec
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: eight_bit_risc_instruction_executor
// Drives preload, readback and execute words into the core with a bursty
// sender and a stalling receiver. An in-bench shadow of the register file,
// data memory, pc and halt flag predicts every result word. Each result is
// checked field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module testbench;
  import erb_pkg::*;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          RANDOM_WORDS = 540;
  localparam logic [3:0]  OP_NOP_LO = 4'd12;
  localparam logic [3:0]  OP_NOP_HI = 4'd14;

  // One result word as the core reports it
  typedef struct packed {
    logic [7:0] next_pc;
    logic       halted;
    logic [7:0] read_data;
    logic       reg_written;
    logic [3:0] reg_index;
    logic [7:0] reg_value;
    logic       mem_written;
    logic [7:0] mem_address;
    logic [7:0] mem_value;
    logic       branch_taken;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = REQ_LOAD_DATA;
  logic [7:0]  in_address = 8'h00;
  logic [7:0]  in_load_value = 8'h00;
  logic [15:0] in_instruction = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_next_pc;
  logic        out_halted;
  logic [7:0]  out_read_data;
  logic        out_reg_written;
  logic [3:0]  out_reg_index;
  logic [7:0]  out_reg_value;
  logic        out_mem_written;
  logic [7:0]  out_mem_address;
  logic [7:0]  out_mem_value;
  logic        out_branch_taken;

  // Shadow state of the core
  logic [7:0]   rf_shadow [16];
  logic [7:0]   dmem_shadow [256];
  logic [15:0]  rf_known = '0;
  logic [255:0] dmem_known = '0;
  logic [7:0]   pc_shadow = 8'h00;
  logic         halt_shadow = 1'b0;

  outcome_t pending_outcomes [$];
  int       mismatch_count = 0;
  int       results_seen = 0;
  int       cycle_count = 0;
  int       burst_left = 1;
  logic     gapless = 1'b0;
  logic [9:0] stall_tick = '0;

  eight_bit_risc_instruction_executor DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_address       (in_address),
    .in_load_value    (in_load_value),
    .in_instruction   (in_instruction),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_next_pc      (out_next_pc),
    .out_halted       (out_halted),
    .out_read_data    (out_read_data),
    .out_reg_written  (out_reg_written),
    .out_reg_index    (out_reg_index),
    .out_reg_value    (out_reg_value),
    .out_mem_written  (out_mem_written),
    .out_mem_address  (out_mem_address),
    .out_mem_value    (out_mem_value),
    .out_branch_taken (out_branch_taken)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] encode(logic [3:0] op, logic [3:0] r1, logic [3:0] r2,
                                         logic [3:0] r3);
    return {op, r1, r2, r3};
  endfunction

  // Bias toward zero and the byte extremes so beqz is taken often
  function automatic logic [7:0] pick_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return 8'h00;
    if (roll < 35) return 8'hFF;
    if (roll < 40) return 8'h80;
    return 8'($urandom);
  endfunction

  // Apply one accepted word to the shadow state and return its result
  function automatic outcome_t retire_word(req_t rt, logic [7:0] addr, logic [7:0] lv,
                                           logic [15:0] ir);
    outcome_t   o;
    logic [3:0] op, r1, r2, r3;
    logic [7:0] a, b, d, val, ea;
    logic       wr;
    o = '0;
    case (rt)
      REQ_LOAD_DATA: begin
        dmem_shadow[addr] = lv;
        dmem_known[addr] = 1'b1;
      end
      REQ_LOAD_REG: begin
        rf_shadow[addr[3:0]] = lv;
        rf_known[addr[3:0]] = 1'b1;
      end
      REQ_READ_DATA: o.read_data = dmem_shadow[addr];
      default: begin
        if (!halt_shadow) begin
          {op, r1, r2, r3} = ir;
          a = rf_shadow[r2];
          b = rf_shadow[r3];
          d = rf_shadow[r1];
          ea = a + {4'd0, r3};
          wr = 1'b1;
          val = 8'h00;
          case (op)
            OP_ADD:  val = a + b;
            OP_SUB:  val = a - b;
            OP_MUL:  val = a * b;
            OP_INC:  val = d + 8'd1;
            OP_AND:  val = a & b;
            OP_OR:   val = a | b;
            OP_NOT:  val = ~a;
            OP_XOR:  val = a ^ b;
            OP_LOAD: val = dmem_shadow[ea];
            default: wr = 1'b0;
          endcase
          if (wr) begin
            rf_shadow[r1] = val;
            rf_known[r1] = 1'b1;
            o.reg_written = 1'b1;
            o.reg_index = r1;
            o.reg_value = val;
          end
          pc_shadow = pc_shadow + 8'd2;
          // Branch offsets count words, so only the low seven offset bits matter mod 256
          case (op)
            OP_STORE: begin
              dmem_shadow[ea] = d;
              dmem_known[ea] = 1'b1;
              o.mem_written = 1'b1;
              o.mem_address = ea;
              o.mem_value = d;
            end
            OP_JMP: begin
              pc_shadow = pc_shadow + {r1[2:0], r2, 1'b0};
              o.branch_taken = 1'b1;
            end
            OP_BEQZ: begin
              if (d == 8'h00) begin
                pc_shadow = pc_shadow + {r2[2:0], r3, 1'b0};
                o.branch_taken = 1'b1;
              end
            end
            OP_HALT: halt_shadow = 1'b1;
            default: ;
          endcase
        end
      end
    endcase
    o.next_pc = pc_shadow;
    o.halted = halt_shadow;
    return o;
  endfunction

  // Present one word, hold it until accepted, then record its result
  task automatic send_word(req_t rt, logic [7:0] addr, logic [7:0] lv, logic [15:0] ir);
    int gap;
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_address <= addr;
    in_load_value <= lv;
    in_instruction <= ir;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_outcomes.push_back(retire_word(rt, addr, lv, ir));
    // End the burst with a random gap unless gapless is set
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gapless ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Preload any storage the word would read before it was ever written
  task automatic put_word(req_t rt, logic [7:0] addr, logic [7:0] lv, logic [15:0] ir);
    logic [7:0] ea;
    logic [3:0] ri;
    if (rt == REQ_READ_DATA && !dmem_known[addr])
      send_word(REQ_LOAD_DATA, addr, pick_byte(), 16'($urandom));
    if (rt == REQ_EXEC && !halt_shadow) begin
      for (int k = 0; k < 3; k++) begin
        ri = ir[4*k +: 4];
        if (!rf_known[ri])
          send_word(REQ_LOAD_REG, {4'($urandom), ri}, pick_byte(), 16'($urandom));
      end
      if (ir[15:12] == OP_LOAD) begin
        ea = rf_shadow[ir[7:4]] + {4'd0, ir[3:0]};
        if (!dmem_known[ea])
          send_word(REQ_LOAD_DATA, ea, pick_byte(), 16'($urandom));
      end
    end
    send_word(rt, addr, lv, ir);
  endtask

  // Hold the sender until every pending result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_outcomes.size() != 0);
  endtask

  task automatic flag_mismatch(string what, int got, int want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch on result %0d: %s got %0h want %0h", results_seen, what, got, want);
  endtask

  task automatic test_preload_and_readback();
    put_word(REQ_LOAD_DATA, 8'h00, 8'hFF, 16'h0000);
    put_word(REQ_LOAD_DATA, 8'hFF, 8'h00, 16'hFFFF);
    put_word(REQ_LOAD_REG, 8'hFF, 8'h80, 16'h0000);
    put_word(REQ_LOAD_REG, 8'hF0, 8'hFF, 16'h0000);
    put_word(REQ_LOAD_REG, 8'h05, 8'h00, 16'h0000);
    put_word(REQ_LOAD_REG, 8'h01, 8'h7F, 16'h0000);
    put_word(REQ_READ_DATA, 8'h00, 8'h00, 16'h0000);
    put_word(REQ_READ_DATA, 8'hFF, 8'h00, 16'h0000);
  endtask

  task automatic test_each_opcode();
    put_word(REQ_EXEC, 8'h00, 8'h00, encode(OP_ADD, 4'd2, 4'd15, 4'd0));
    put_word(REQ_EXEC, 8'h00, 8'h00, encode(OP_SUB, 4'd3, 4'd5, 4'd0));
    put_word(REQ_EXEC, 8'h00, 8'h00, encode(OP_MUL, 4'd4, 4'd0, 4'd0));
    put_word(REQ_EXEC, 8'h00, 8'h00, encode(OP_INC, 4'd0, 4'd0, 4'd0));
    put_word(REQ_EXEC, 8'h00, 8'h00, encode(OP_AND, 4'd6, 4'd15, 4'd1));
    put_word(REQ_EXEC, 8'h00, 8'h00, encode(OP_OR, 4'd7, 4'd15, 4'd1));
    put_word(REQ_EXEC, 8'h00, 8'h00, encode(OP_NOT, 4'd8, 4'd5, 4'd0));
    put_word(REQ_EXEC, 8'h00, 8'h00, encode(OP_XOR, 4'd9, 4'd7, 4'd1));
    put_word(REQ_EXEC, 8'h00, 8'h00, encode(OP_STORE, 4'd7, 4'd9, 4'd15));
    put_word(REQ_EXEC, 8'h00, 8'h00, encode(OP_LOAD, 4'd10, 4'd9, 4'd15));
    // Effective address wraps past 255
    put_word(REQ_EXEC, 8'h00, 8'h00, encode(OP_STORE, 4'd15, 4'd7, 4'd15));
    put_word(REQ_EXEC, 8'h00, 8'h00, encode(OP_LOAD, 4'd11, 4'd7, 4'd15));
    // Largest and smallest jump offsets
    put_word(REQ_EXEC, 8'h00, 8'h00, encode(OP_JMP, 4'd7, 4'd15, 4'd0));
    put_word(REQ_EXEC, 8'h00, 8'h00, encode(OP_JMP, 4'd8, 4'd0, 4'd0));
    put_word(REQ_EXEC, 8'h00, 8'h00, encode(OP_BEQZ, 4'd5, 4'd15, 4'd15));
    put_word(REQ_EXEC, 8'h00, 8'h00, encode(OP_BEQZ, 4'd1, 4'd0, 4'd1));
    put_word(REQ_EXEC, 8'h00, 8'h00, encode(OP_NOP_LO, 4'd3, 4'd4, 4'd5));
    put_word(REQ_EXEC, 8'h00, 8'h00, encode(OP_NOP_HI, 4'd15, 4'd15, 4'd15));
    put_word(REQ_READ_DATA, 8'h8F, 8'h00, 16'h0000);
  endtask

  // Mostly execute words; halt is left out unless allowed
  task automatic test_random_traffic(int count, logic allow_halt);
    int          roll;
    req_t        rt;
    logic [15:0] ir;
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) gapless = ($urandom_range(0, 2) == 0);
      roll = $urandom_range(0, 99);
      ir = 16'($urandom);
      if (roll < 70) begin
        rt = REQ_EXEC;
        if (!allow_halt && ir[15:12] == OP_HALT) ir[15:12] = 4'($urandom_range(0, 14));
      end else if (roll < 80) begin
        rt = REQ_LOAD_REG;
      end else if (roll < 88) begin
        rt = REQ_LOAD_DATA;
      end else begin
        rt = REQ_READ_DATA;
      end
      put_word(rt, 8'($urandom), pick_byte(), ir);
    end
    gapless = 1'b0;
  endtask

  // Halt last: after it, execute words change nothing but loads and reads still work
  task automatic test_halt();
    put_word(REQ_EXEC, 8'h00, 8'h00, encode(OP_HALT, 4'($urandom), 4'($urandom),
                                            4'($urandom)));
    test_random_traffic(40, 1'b1);
  endtask

  // Receiver stall pattern, changing character with bits 9:8 of stall_tick
  always @(posedge clk) begin
    stall_tick <= stall_tick + 10'd1;
    case (stall_tick[9:8])
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 99) < 30);
      2'd2:    out_stall <= (stall_tick[2:0] < 3'd3);
      default: out_stall <= ($urandom_range(0, 99) < 60);
    endcase
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_next_pc, out_halted, out_read_data, out_reg_written, out_reg_index,
             out_reg_value, out_mem_written, out_mem_address, out_mem_value,
             out_branch_taken};
      if (pending_outcomes.size() == 0) begin
        flag_mismatch("unexpected result", int'(got.next_pc), 0);
      end else begin
        want = pending_outcomes.pop_front();
        if (got.next_pc !== want.next_pc) flag_mismatch("next_pc", got.next_pc, want.next_pc);
        if (got.halted !== want.halted) flag_mismatch("halted", got.halted, want.halted);
        if (got.read_data !== want.read_data)
          flag_mismatch("read_data", got.read_data, want.read_data);
        if (got.reg_written !== want.reg_written)
          flag_mismatch("reg_written", got.reg_written, want.reg_written);
        if (got.reg_index !== want.reg_index)
          flag_mismatch("reg_index", got.reg_index, want.reg_index);
        if (got.reg_value !== want.reg_value)
          flag_mismatch("reg_value", got.reg_value, want.reg_value);
        if (got.mem_written !== want.mem_written)
          flag_mismatch("mem_written", got.mem_written, want.mem_written);
        if (got.mem_address !== want.mem_address)
          flag_mismatch("mem_address", got.mem_address, want.mem_address);
        if (got.mem_value !== want.mem_value)
          flag_mismatch("mem_value", got.mem_value, want.mem_value);
        if (got.branch_taken !== want.branch_taken)
          flag_mismatch("branch_taken", got.branch_taken, want.branch_taken);
      end
      results_seen++;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_preload_and_readback();
    test_each_opcode();
    drain();
    test_random_traffic(RANDOM_WORDS, 1'b0);
    drain();
    test_random_traffic(RANDOM_WORDS, 1'b0);
    test_halt();
    // Wait out the last results plus the pipeline depth
    drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- eight_bit_risc_instruction_executor.f -----
design/erb_pkg.sv
design/erb_ram.sv
design/erb_exec.sv
design/eight_bit_risc_instruction_executor.sv
sim/testbench.sv
